FILE: rtl/core/fpfa_pkg.sv
// fpfa_pkg: shared constants, codes and types of the fixed partition fit allocator
// used by fpfa_ctrl, fpfa_dp and fixed_partition_fit_allocator
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int PARTITIONS = 4;
    localparam int SIZE_BITS  = 16;
    localparam int PART_BITS  = 2;
    localparam int CFG_BITS   = 3;
    localparam int DATA_BITS  = 16;
    localparam int MODE_BITS  = 2;
    localparam int STAT_BITS  = 2;

    localparam logic [PART_BITS-1:0] LAST_PART = PART_BITS'(PARTITIONS - 1);

    localparam logic OP_PLACE   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [MODE_BITS-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_WORST = 2'd2;

    localparam logic [STAT_BITS-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_NO_ROOM  = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_NEVER    = 2'd2;
    localparam logic [STAT_BITS-1:0] STAT_OVERFLOW = 2'd3;

    localparam logic [CFG_BITS-1:0] CFG_FIT_MODE = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_PART_0  = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_PART_3  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                 load;
        logic                 scan;
        logic                 finish;
        logic [PART_BITS-1:0] scan_idx;
    } t_cmd;

endpackage

FILE: rtl/core/fixed_partition_fit_allocator.sv
// fixed_partition_fit_allocator: top level, fpfa_ctrl sequencer plus fpfa_dp datapath
// depends on fpfa_pkg, fpfa_ctrl, fpfa_dp
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   opcode, request_size, target_partition
// out       output     o_out_valid / i_out_stall status, chosen_partition, free_after
// cfg       input      i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// a place beat steps through accept, one compare per partition in the scan state, then commit
// a release beat skips the scan: accept, then commit
// the result register frees the input side; commit waits only while a result beat is stalled
// synchronous active-low reset clears all sizes, free space and fit mode to zero
`timescale 1ns / 1ps

module fixed_partition_fit_allocator
    import fpfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_in_opcode,
    input  logic [SIZE_BITS-1:0] i_in_request_size,
    input  logic [PART_BITS-1:0] i_in_target_partition,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAT_BITS-1:0] o_out_status,
    output logic [PART_BITS-1:0] o_out_chosen_partition,
    output logic [SIZE_BITS-1:0] o_out_free_after,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_BITS-1:0]  i_cfg_index,
    input  logic [DATA_BITS-1:0] i_cfg_data
);

    t_cmd w_cmd;
    logic w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    fpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_opcode (i_in_opcode),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    fpfa_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_cfg_we           (w_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_opcode           (i_in_opcode),
        .i_request_size     (i_in_request_size),
        .i_target_partition (i_in_target_partition),
        .o_status           (o_out_status),
        .o_chosen_partition (o_out_chosen_partition),
        .o_free_after       (o_out_free_after)
    );

endmodule

FILE: rtl/core/fpfa_ctrl.sv
// fpfa_ctrl: sequencer for accept, partition scan and result hand-off
// depends on fpfa_pkg
`timescale 1ns / 1ps

module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_opcode,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state               r_state, n_state;
    logic [PART_BITS-1:0] r_scan_idx, n_scan_idx;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;
    logic                 w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_opcode == OP_RELEASE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan_idx == LAST_PART) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.scan_idx = r_scan_idx;
        n_scan_idx     = r_scan_idx;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = w_accept;
                n_scan_idx = '0;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                n_scan_idx = r_scan_idx + 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = w_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || !i_out_stall))
        else $error("result committed while output beat still stalled");

    a_scan_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_opcode == OP_PLACE) |=> (r_state == ST_SCAN && r_scan_idx == '0))
        else $error("scan did not start at partition zero");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.finish))
        else $error("output valid rose without a finished item");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan || o_cmd.finish) |-> !o_cmd.load)
        else $error("input beat taken while an item is in work");

endmodule

FILE: rtl/core/fpfa_dp.sv
// fpfa_dp: partition sizes, free space, fit scan and result registers
// depends on fpfa_pkg, driven by fpfa_ctrl commands
`timescale 1ns / 1ps

module fpfa_dp
    import fpfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_BITS-1:0]  i_cfg_index,
    input  logic [DATA_BITS-1:0] i_cfg_data,
    input  logic                 i_opcode,
    input  logic [SIZE_BITS-1:0] i_request_size,
    input  logic [PART_BITS-1:0] i_target_partition,
    output logic [STAT_BITS-1:0] o_status,
    output logic [PART_BITS-1:0] o_chosen_partition,
    output logic [SIZE_BITS-1:0] o_free_after
);

    logic [SIZE_BITS-1:0] r_part_size [PARTITIONS];
    logic [SIZE_BITS-1:0] r_free      [PARTITIONS];
    logic [MODE_BITS-1:0] r_fit_mode;

    logic                 r_op;
    logic [SIZE_BITS-1:0] r_size;
    logic [PART_BITS-1:0] r_tgt;
    logic                 r_ever;
    logic                 r_found;
    logic [PART_BITS-1:0] r_pick;
    logic [SIZE_BITS-1:0] r_best;

    logic [STAT_BITS-1:0] r_status;
    logic [PART_BITS-1:0] r_chosen;
    logic [SIZE_BITS-1:0] r_free_after;

    logic [PART_BITS-1:0] w_rd_idx;
    logic [SIZE_BITS-1:0] w_cap;
    logic [SIZE_BITS-1:0] w_free;
    logic                 w_fits;
    logic [SIZE_BITS-1:0] w_left;
    logic                 w_take;
    logic [SIZE_BITS:0]   w_sum;
    logic                 w_ovf;
    logic [PART_BITS-1:0] w_cfg_part;
    logic                 w_cfg_size;

    assign w_rd_idx = (r_op == OP_RELEASE) ? r_tgt : i_cmd.scan_idx;
    assign w_cap    = r_part_size[w_rd_idx];
    assign w_free   = r_free[w_rd_idx];
    assign w_fits   = (w_free >= r_size);
    assign w_left   = w_free - r_size;
    assign w_sum    = {1'b0, w_free} + {1'b0, r_size};
    assign w_ovf    = (w_sum > {1'b0, w_cap});

    assign w_cfg_size = i_cfg_we && (i_cfg_index >= CFG_PART_0) && (i_cfg_index <= CFG_PART_3);
    assign w_cfg_part = PART_BITS'(i_cfg_index - CFG_PART_0);

    always_comb begin
        w_take = 1'b0;
        if (w_fits) begin
            case (r_fit_mode)
                MODE_BEST:  w_take = !r_found || (w_left < r_best);
                MODE_WORST: w_take = !r_found || (w_left > r_best);
                default:    w_take = !r_found;
            endcase
        end
    end

    // configuration and free space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= MODE_FIRST;
            for (int i = 0; i < PARTITIONS; i++) begin
                r_part_size[i] <= '0;
                r_free[i]      <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_FIT_MODE) begin
                r_fit_mode <= i_cfg_data[MODE_BITS-1:0];
            end
            if (w_cfg_size) begin
                r_part_size[w_cfg_part] <= i_cfg_data[SIZE_BITS-1:0];
                r_free[w_cfg_part]      <= i_cfg_data[SIZE_BITS-1:0];
            end
            if (i_cmd.finish) begin
                if (r_op == OP_RELEASE) begin
                    r_free[r_tgt] <= w_ovf ? w_cap : w_sum[SIZE_BITS-1:0];
                end else if (r_ever && r_found) begin
                    r_free[r_pick] <= r_best;
                end
            end
        end
    end

    // item capture and scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_PLACE;
            r_ever  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_ever  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            if (w_cap >= r_size) begin
                r_ever <= 1'b1;
            end
            if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size <= i_request_size;
            r_tgt  <= i_target_partition;
        end
        if (i_cmd.scan && w_take) begin
            r_pick <= i_cmd.scan_idx;
            r_best <= w_left;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_op == OP_RELEASE) begin
                r_status     <= w_ovf ? STAT_OVERFLOW : STAT_DONE;
                r_chosen     <= r_tgt;
                r_free_after <= w_ovf ? w_cap : w_sum[SIZE_BITS-1:0];
            end else if (!r_ever) begin
                r_status     <= STAT_NEVER;
                r_chosen     <= '0;
                r_free_after <= '0;
            end else if (!r_found) begin
                r_status     <= STAT_NO_ROOM;
                r_chosen     <= '0;
                r_free_after <= '0;
            end else begin
                r_status     <= STAT_DONE;
                r_chosen     <= r_pick;
                r_free_after <= r_best;
            end
        end
    end

    assign o_status           = r_status;
    assign o_chosen_partition = r_chosen;
    assign o_free_after       = r_free_after;

endmodule

FILE: tb/tb_fixed_partition_fit_allocator.sv
// tb_fixed_partition_fit_allocator: self-checking testbench for the fit allocator
// directed table then random place/release beats under four idle/stall phases
// depends on fpfa_pkg and fixed_partition_fit_allocator
`timescale 1ns / 1ps

module tb_fixed_partition_fit_allocator;
    import fpfa_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BEATS_PER_PHASE = 138;
    localparam int PLAN_ROWS = 34;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [PART_BITS-1:0] part;
        logic [SIZE_BITS-1:0] free;
    } t_outcome;

    typedef struct packed {
        logic     fixed;
        t_outcome value;
    } t_fixed_outcome;

    typedef struct packed {
        logic                 cfg;
        logic [CFG_BITS-1:0]  idx;
        logic                 op;
        logic [SIZE_BITS-1:0] val;
        logic [PART_BITS-1:0] tgt;
        logic                 fixed;
        logic [STAT_BITS-1:0] status;
        logic [PART_BITS-1:0] part;
        logic [SIZE_BITS-1:0] free;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_in_opcode = OP_PLACE;
    logic [SIZE_BITS-1:0] i_in_request_size = '0;
    logic [PART_BITS-1:0] i_in_target_partition = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STAT_BITS-1:0] o_out_status;
    logic [PART_BITS-1:0] o_out_chosen_partition;
    logic [SIZE_BITS-1:0] o_out_free_after;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_BITS-1:0]  i_cfg_index = '0;
    logic [DATA_BITS-1:0] i_cfg_data = '0;

    logic [MODE_BITS-1:0] fit_policy = MODE_FIRST;
    logic [SIZE_BITS-1:0] part_cap [PARTITIONS];
    logic [SIZE_BITS-1:0] part_free [PARTITIONS];

    t_outcome       outcome_q [$];
    t_fixed_outcome fixed_q [$];
    int             error_count = 0;
    int             idle_cycles = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;

    t_plan_row plan [PLAN_ROWS] = '{
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd0, 2'd0, 1'b1, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd1, 2'd0, 1'b1, STAT_NEVER, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'hFFFF, 2'd3, 1'b1, STAT_NEVER, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'd0, 2'd3, 1'b1, STAT_DONE, 2'd3, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'hFFFF, 2'd2, 1'b1, STAT_OVERFLOW, 2'd2, 16'd0},
        '{1'b1, CFG_PART_0, OP_PLACE, 16'd100, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, 3'(CFG_PART_0 + 1), OP_PLACE, 16'hFFFF, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, 3'(CFG_PART_0 + 2), OP_PLACE, 16'd40, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, CFG_PART_3, OP_PLACE, 16'd0, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'hFFFF, 2'd0, 1'b1, STAT_DONE, 2'd1, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'hFFFF, 2'd0, 1'b1, STAT_NO_ROOM, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'hFFFF, 2'd1, 1'b1, STAT_DONE, 2'd1, 16'hFFFF},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'd1, 2'd1, 1'b1, STAT_OVERFLOW, 2'd1, 16'hFFFF},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd40, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, CFG_FIT_MODE, OP_PLACE, 16'(MODE_BEST), 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd40, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd20, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd0, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, CFG_FIT_MODE, OP_PLACE, 16'(MODE_WORST), 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd40, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd0, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, CFG_FIT_MODE, OP_PLACE, 16'hFFFF, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd40, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'd5, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, 3'(CFG_PART_3 + 1), OP_PLACE, 16'h5A5A, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, 3'(CFG_PART_3 + 3), OP_PLACE, 16'hFFFF, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd5, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'hFFFF, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, CFG_FIT_MODE, OP_PLACE, {14'h3FFF, MODE_WORST}, 2'd0, 1'b0, STAT_DONE, 2'd0,
          16'd0},
        '{1'b1, CFG_PART_0, OP_PLACE, 16'd50, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b1, 3'(CFG_PART_0 + 1), OP_PLACE, 16'd50, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd10, 2'd0, 1'b0, STAT_DONE, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_PLACE, 16'd51, 2'd0, 1'b1, STAT_NEVER, 2'd0, 16'd0},
        '{1'b0, CFG_FIT_MODE, OP_RELEASE, 16'd3, 2'd3, 1'b1, STAT_OVERFLOW, 2'd3, 16'd0}
    };

    fixed_partition_fit_allocator uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_in_opcode            (i_in_opcode),
        .i_in_request_size      (i_in_request_size),
        .i_in_target_partition  (i_in_target_partition),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_out_status           (o_out_status),
        .o_out_chosen_partition (o_out_chosen_partition),
        .o_out_free_after       (o_out_free_after),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void load_register(input logic [CFG_BITS-1:0] idx,
                                          input logic [DATA_BITS-1:0] data);
        if (idx == CFG_FIT_MODE) begin
            fit_policy = data[MODE_BITS-1:0];
        end else if (idx <= CFG_PART_3) begin
            part_cap[PART_BITS'(idx - CFG_PART_0)]  = data[SIZE_BITS-1:0];
            part_free[PART_BITS'(idx - CFG_PART_0)] = data[SIZE_BITS-1:0];
        end
    endfunction

    function automatic t_outcome alloc_outcome(input logic op, input logic [SIZE_BITS-1:0] size,
                                               input logic [PART_BITS-1:0] tgt);
        t_outcome             res;
        logic [SIZE_BITS:0]   sum;
        logic [SIZE_BITS-1:0] left;
        logic [SIZE_BITS-1:0] best;
        int                   pick;
        bit                   ever;
        bit                   found;
        res   = '0;
        ever  = 1'b0;
        found = 1'b0;
        pick  = 0;
        best  = '0;
        if (op == OP_RELEASE) begin
            sum = {1'b0, part_free[tgt]} + {1'b0, size};
            if (sum > {1'b0, part_cap[tgt]}) begin
                part_free[tgt] = part_cap[tgt];
                res.status     = STAT_OVERFLOW;
            end else begin
                part_free[tgt] = sum[SIZE_BITS-1:0];
                res.status     = STAT_DONE;
            end
            res.part = tgt;
            res.free = part_free[tgt];
            return res;
        end
        for (int i = 0; i < PARTITIONS; i++) begin
            if (part_cap[i] >= size) ever = 1'b1;
        end
        if (!ever) begin
            res.status = STAT_NEVER;
            return res;
        end
        for (int i = 0; i < PARTITIONS; i++) begin
            if (part_free[i] >= size) begin
                left = part_free[i] - size;
                if (!found || (fit_policy == MODE_BEST && left < best)
                        || (fit_policy == MODE_WORST && left > best)) begin
                    found = 1'b1;
                    pick  = i;
                    best  = left;
                end
                if (fit_policy != MODE_BEST && fit_policy != MODE_WORST) break;
            end
        end
        if (!found) begin
            res.status = STAT_NO_ROOM;
            return res;
        end
        part_free[pick] = part_free[pick] - size;
        res.status      = STAT_DONE;
        res.part        = PART_BITS'(pick);
        res.free        = part_free[pick];
        return res;
    endfunction

    // scoreboard: config and input beats update the prediction, output beats are checked
    always @(posedge i_clk) begin : monitor
        t_outcome       want;
        t_fixed_outcome slot;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                load_register(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                want = alloc_outcome(i_in_opcode, i_in_request_size, i_in_target_partition);
                if (fixed_q.size() != 0) begin
                    slot = fixed_q.pop_front();
                    if (slot.fixed) want = slot.value;
                end
                outcome_q = {outcome_q, want};
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result beat, status %0d part %0d free %0d",
                             $time, o_out_status, o_out_chosen_partition, o_out_free_after);
                    error_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_out_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_out_status);
                        error_count++;
                    end
                    if (o_out_chosen_partition !== want.part) begin
                        $display("%0t: chosen_partition expected %0d actual %0d",
                                 $time, want.part, o_out_chosen_partition);
                        error_count++;
                    end
                    if (o_out_free_after !== want.free) begin
                        $display("%0t: free_after expected %0d actual %0d",
                                 $time, want.free, o_out_free_after);
                        error_count++;
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb_fixed_partition_fit_allocator: FAIL");
        $finish;
    end

    task automatic send_beat(input logic op, input logic [SIZE_BITS-1:0] size,
                             input logic [PART_BITS-1:0] tgt, input logic fixed,
                             input t_outcome value);
        t_fixed_outcome slot;
        slot.fixed = fixed;
        slot.value = value;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_opcode           = op;
        i_in_request_size     = size;
        i_in_target_partition = tgt;
        i_in_valid            = 1'b1;
        fixed_q = {fixed_q, slot};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_capacity();
        case ($urandom_range(3))
            0:       return SIZE_BITS'($urandom_range(255));
            1:       return SIZE_BITS'($urandom);
            2:       return '1;
            default: return SIZE_BITS'($urandom_range(4000));
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] pick_size(input logic [PART_BITS-1:0] tgt);
        int unsigned top;
        top = 0;
        for (int i = 0; i < PARTITIONS; i++) begin
            if (32'(part_cap[i]) > top) top = 32'(part_cap[i]);
        end
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return SIZE_BITS'($urandom);
            3:       return part_cap[tgt] + 1'b1;
            4:       return part_free[tgt];
            default: return SIZE_BITS'($urandom_range(top / 4 + 1));
        endcase
    endfunction

    initial begin : stimulus
        logic [SIZE_BITS-1:0] caps [PARTITIONS];
        logic [MODE_BITS-1:0] mode;
        logic [PART_BITS-1:0] tgt;
        logic                 op;
        for (int i = 0; i < PARTITIONS; i++) begin
            part_cap[i]  = '0;
            part_free[i] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].cfg) begin
                drain();
                write_reg(plan[r].idx, plan[r].val);
            end else begin
                send_beat(plan[r].op, plan[r].val, plan[r].tgt, plan[r].fixed,
                          '{plan[r].status, plan[r].part, plan[r].free});
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    mode      = MODE_FIRST;
                    for (int i = 0; i < PARTITIONS; i++) caps[i] = '1;
                end
                1: begin
                    idle_pct  = 46;
                    stall_pct = 0;
                    mode      = MODE_BEST;
                    for (int i = 0; i < PARTITIONS; i++) caps[i] = pick_capacity();
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 46;
                    mode      = MODE_WORST;
                    for (int i = 0; i < PARTITIONS; i++) caps[i] = pick_capacity();
                end
                default: begin
                    idle_pct  = 32;
                    stall_pct = 32;
                    mode      = MODE_SPARE;
                    caps[0]   = '0;
                    caps[1]   = 16'd1;
                    caps[2]   = SIZE_BITS'($urandom_range(500));
                    caps[3]   = '1;
                    write_reg(3'(CFG_PART_3 + $urandom_range(1, 3)), DATA_BITS'($urandom));
                end
            endcase
            write_reg(CFG_FIT_MODE, {(DATA_BITS - MODE_BITS)'($urandom), mode});
            for (int i = 0; i < PARTITIONS; i++) write_reg(3'(CFG_PART_0 + i), caps[i]);

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // hold off mid-phase until every result is back
                if (n == BEATS_PER_PHASE / 2) drain();
                op  = ($urandom_range(99) < 40) ? OP_RELEASE : OP_PLACE;
                tgt = PART_BITS'($urandom_range(PARTITIONS - 1));
                send_beat(op, pick_size(tgt), tgt, 1'b0, '0);
            end
        end

        i_in_valid = 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("tb_fixed_partition_fit_allocator: PASS");
        end else begin
            $display("tb_fixed_partition_fit_allocator: FAIL");
        end
        $finish;
    end

endmodule
